@@ hw/rtl/pscc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position/speed cascade controller package
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
package pscc_pkg;

  // Default number of fractional bits of every fixed-point quantity.
  localparam int FracBitsDef = 16;

  // pi and 2*pi with 30 fractional bits, rounded to the target precision later.
  localparam logic [63:0] PiQ30    = 64'd3373259426;
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  // Field widths.
  localparam int AngleW  = 19;
  localparam int SpeedW  = 27;
  localparam int GainW   = 24;
  localparam int IqW     = 25;
  localparam int TdataW  = 72;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 27;

  // Shared multiplier: unsigned gain times signed operand.
  localparam int MulAW  = GainW + 1;
  localparam int MulBW  = 32;
  localparam int ProdW  = MulAW + MulBW;
  localparam int AccW   = ProdW + 1;
  localparam int IntegW = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPositionGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpeedGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedIGainDt = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpeedFloor   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedCeiling = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCurrentLimit = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [GainW-1:0]         RstPositionGain = 24'd65536;
  localparam logic [GainW-1:0]         RstSpeedGain    = 24'd65536;
  localparam logic [GainW-1:0]         RstSpeedIGainDt = 24'd655;
  localparam logic signed [SpeedW-1:0] RstSpeedFloor   = -27'sd6553600;
  localparam logic signed [SpeedW-1:0] RstSpeedCeiling = 27'sd6553600;
  localparam logic [GainW-1:0]         RstCurrentLimit = 24'd131072;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [GainW-1:0]         position_gain;
    logic [GainW-1:0]         speed_gain;
    logic [GainW-1:0]         speed_integral_gain_dt;
    logic signed [SpeedW-1:0] speed_floor;
    logic signed [SpeedW-1:0] speed_ceiling;
    logic [GainW-1:0]         current_limit;
  } cfg_t;

  // Operands presented to the shared multiplier.
  typedef struct packed {
    logic [GainW-1:0]        gain;
    logic signed [MulBW-1:0] operand;
  } mul_req_t;

endpackage

@@ hw/rtl/pscc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// Decodes the plain write port into the six controller settings.
// ----------------------------------------------------------------------------
module pscc_cfg_regs import pscc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  // Writes to an index outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_gain          <= RstPositionGain;
      cfg_q.speed_gain             <= RstSpeedGain;
      cfg_q.speed_integral_gain_dt <= RstSpeedIGainDt;
      cfg_q.speed_floor            <= RstSpeedFloor;
      cfg_q.speed_ceiling          <= RstSpeedCeiling;
      cfg_q.current_limit          <= RstCurrentLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPositionGain: cfg_q.position_gain          <= cfg_wdata_i[GainW-1:0];
        RegSpeedGain:    cfg_q.speed_gain             <= cfg_wdata_i[GainW-1:0];
        RegSpeedIGainDt: cfg_q.speed_integral_gain_dt <= cfg_wdata_i[GainW-1:0];
        RegSpeedFloor:   cfg_q.speed_floor            <= $signed(cfg_wdata_i[SpeedW-1:0]);
        RegSpeedCeiling: cfg_q.speed_ceiling          <= $signed(cfg_wdata_i[SpeedW-1:0]);
        RegCurrentLimit: cfg_q.current_limit          <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/pscc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared gain multiplier
// Unsigned gain times signed operand, product registered for the next cycle.
// ----------------------------------------------------------------------------
module pscc_mul import pscc_pkg::*; (
  input  logic                    clk_i,
  input  mul_req_t                req_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [MulAW-1:0] gain_s;

  // The gain is zero-extended so that a signed multiply keeps it positive.
  assign gain_s = $signed({1'b0, req_i.gain});

  always_ff @(posedge clk_i) begin
    prod_q <= gain_s * req_i.operand;
  end

  assign prod_o = prod_q;

endmodule

@@ hw/rtl/position_speed_cascade_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position/speed cascade controller
// Position P loop feeding a clamped speed PI loop that yields the q-axis
// current reference, computed on one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Contents
//  s_axis   in         tvalid/tready           target_position, mech_angle,
//                                              measured_speed
//  m_axis   out        tvalid/tready           position_error, speed_target,
//                                              q_current_ref
//  cfg      in         cfg_we_i (no wait)      six controller settings
//
//  An item runs from acceptance through the sequencer steps into the output
//  register, with three passes through the shared multiplier and one shared
//  clamp unit. The input is not ready while an item is in work and is ready
//  again the cycle after its hand-over, so a new request is taken only once
//  the last is through. A finished result waits in the sequencer's last step
//  while the output register still holds an untaken result. Reset clears the
//  integrator, the settings to their defaults and all handshake state.
// ----------------------------------------------------------------------------
module position_speed_cascade_controller_unit import pscc_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Fields from bit 0: target_position[18:0], mech_angle[37:19],
  // measured_speed[64:38], zero padding.
  input  logic [TdataW-1:0]  s_axis_tdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // Fields from bit 0: position_error[18:0], speed_target[45:19],
  // q_current_ref[70:46], zero padding.
  output logic [TdataW-1:0]  m_axis_tdata_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i
);

  // Position error carries headroom for pi at the finest precision.
  localparam int ErrW  = 30;
  localparam int SerrW = SpeedW + 1;
  localparam logic [63:0] PiWide    = (PiQ30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [63:0] TwoPiWide = (TwoPiQ30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic signed [ErrW-1:0] PiFix    = $signed(PiWide[ErrW-1:0]);
  localparam logic signed [ErrW-1:0] TwoPiFix = $signed(TwoPiWide[ErrW-1:0]);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_WRAP, ST_MUL_POS, ST_CLAMP_SPD, ST_SERR, ST_MUL_INT,
    ST_INT_ADD, ST_INT_CLAMP, ST_MUL_PROP, ST_SUM, ST_OUT_CLAMP, ST_DONE
  } state_e;

  cfg_t                    cfg;
  mul_req_t                mul_req;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] scaled;
  logic signed [AccW-1:0]  scaled_ext;
  logic signed [AccW-1:0]  integ_ext;
  logic signed [AccW-1:0]  lim_pos;
  logic signed [AccW-1:0]  lim_neg;
  logic signed [AccW-1:0]  clamp_v, clamp_lo, clamp_hi, clamp_r;
  logic                    in_acc, out_load;

  state_e                   state_q, state_d;
  logic [AngleW-1:0]        tgt_q, tgt_d, ang_q, ang_d;
  logic signed [SpeedW-1:0] meas_q, meas_d;
  logic signed [ErrW-1:0]   err_q, err_d;
  logic signed [SpeedW-1:0] spd_q, spd_d;
  logic signed [SerrW-1:0]  serr_q, serr_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [IqW-1:0]    iq_q, iq_d;
  logic                     out_valid_q, out_valid_d;
  logic [AngleW-1:0]        out_err_q, out_err_d;
  logic [SpeedW-1:0]        out_spd_q, out_spd_d;
  logic [IqW-1:0]           out_iq_q, out_iq_d;

  pscc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pscc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Product back to the working precision, rounding toward minus infinity.
  assign scaled     = prod >>> FRAC_BITS;
  assign scaled_ext = {scaled[ProdW-1], scaled};
  assign integ_ext  = {{(AccW-IntegW){integ_q[IntegW-1]}}, integ_q};
  assign lim_pos    = $signed({{(AccW-GainW){1'b0}}, cfg.current_limit});
  assign lim_neg    = -lim_pos;

  // Shared clamp unit: the lower bound is tested first.
  always_comb begin
    if (clamp_v < clamp_lo) begin
      clamp_r = clamp_lo;
    end else if (clamp_v > clamp_hi) begin
      clamp_r = clamp_hi;
    end else begin
      clamp_r = clamp_v;
    end
  end

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // Sequencer: one arithmetic step per state.
  always_comb begin
    state_d     = state_q;
    tgt_d       = tgt_q;
    ang_d       = ang_q;
    meas_d      = meas_q;
    err_d       = err_q;
    spd_d       = spd_q;
    serr_d      = serr_q;
    acc_d       = acc_q;
    integ_d     = integ_q;
    iq_d        = iq_q;
    out_err_d   = out_err_q;
    out_spd_d   = out_spd_q;
    out_iq_d    = out_iq_q;
    out_valid_d = out_valid_q;
    mul_req     = '0;
    clamp_v     = scaled_ext;
    clamp_lo    = lim_neg;
    clamp_hi    = lim_pos;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tgt_d   = s_axis_tdata_i[AngleW-1:0];
          ang_d   = s_axis_tdata_i[2*AngleW-1:AngleW];
          meas_d  = $signed(s_axis_tdata_i[2*AngleW+SpeedW-1:2*AngleW]);
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        err_d   = $signed({{(ErrW-AngleW){1'b0}}, tgt_q})
                - $signed({{(ErrW-AngleW){1'b0}}, ang_q});
        state_d = ST_WRAP;
      end
      // One add or subtract of 2*pi at most.
      ST_WRAP: begin
        if (err_q > PiFix) begin
          err_d = err_q - TwoPiFix;
        end else if (err_q < -PiFix) begin
          err_d = err_q + TwoPiFix;
        end
        state_d = ST_MUL_POS;
      end
      ST_MUL_POS: begin
        mul_req.gain    = cfg.position_gain;
        mul_req.operand = {{(MulBW-ErrW){err_q[ErrW-1]}}, err_q};
        state_d         = ST_CLAMP_SPD;
      end
      ST_CLAMP_SPD: begin
        clamp_v  = scaled_ext;
        clamp_lo = {{(AccW-SpeedW){cfg.speed_floor[SpeedW-1]}}, cfg.speed_floor};
        clamp_hi = {{(AccW-SpeedW){cfg.speed_ceiling[SpeedW-1]}}, cfg.speed_ceiling};
        spd_d    = clamp_r[SpeedW-1:0];
        state_d  = ST_SERR;
      end
      ST_SERR: begin
        serr_d  = {spd_q[SpeedW-1], spd_q} - {meas_q[SpeedW-1], meas_q};
        state_d = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        mul_req.gain    = cfg.speed_integral_gain_dt;
        mul_req.operand = {{(MulBW-SerrW){serr_q[SerrW-1]}}, serr_q};
        state_d         = ST_INT_ADD;
      end
      ST_INT_ADD: begin
        acc_d   = integ_ext + scaled_ext;
        state_d = ST_INT_CLAMP;
      end
      // The integrator is kept within the current limit.
      ST_INT_CLAMP: begin
        clamp_v = acc_q;
        integ_d = clamp_r[IntegW-1:0];
        state_d = ST_MUL_PROP;
      end
      ST_MUL_PROP: begin
        mul_req.gain    = cfg.speed_gain;
        mul_req.operand = {{(MulBW-SerrW){serr_q[SerrW-1]}}, serr_q};
        state_d         = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = scaled_ext + integ_ext;
        state_d = ST_OUT_CLAMP;
      end
      ST_OUT_CLAMP: begin
        clamp_v = acc_q;
        iq_d    = clamp_r[IqW-1:0];
        state_d = ST_DONE;
      end
      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (out_load) begin
          out_err_d   = err_q[AngleW-1:0];
          out_spd_d   = spd_q;
          out_iq_d    = iq_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, working registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tgt_q       <= '0;
      ang_q       <= '0;
      meas_q      <= '0;
      err_q       <= '0;
      spd_q       <= '0;
      serr_q      <= '0;
      acc_q       <= '0;
      integ_q     <= '0;
      iq_q        <= '0;
      out_err_q   <= '0;
      out_spd_q   <= '0;
      out_iq_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      ang_q       <= ang_d;
      meas_q      <= meas_d;
      err_q       <= err_d;
      spd_q       <= spd_d;
      serr_q      <= serr_d;
      acc_q       <= acc_d;
      integ_q     <= integ_d;
      iq_q        <= iq_d;
      out_err_q   <= out_err_d;
      out_spd_q   <= out_spd_d;
      out_iq_q    <= out_iq_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TdataW-AngleW-SpeedW-IqW){1'b0}}, out_iq_q, out_spd_q, out_err_q};

endmodule

@@ hw/rtl/pscc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the cascade controller
// Watches the stream ports for sequencing and handshake slips.
// ----------------------------------------------------------------------------
module pscc_checker import pscc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [TdataW-1:0] m_axis_tdata_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i
);

  // Once a request is taken the block is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input still ready right after a request was taken");

  // A new result only appears out of the busy sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a request in work");

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result withdrawn before it was taken");

  // A waiting result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while waiting");

endmodule

bind position_speed_cascade_controller_unit pscc_checker u_pscc_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the position/speed cascade controller
// Sends control requests over the input stream and writes the six settings
// between phases. An independent fixed-point model of the position P loop
// and the speed PI loop predicts every result that a directed row does not
// give itself. Each result on the output stream is checked field by field
// against the oldest prediction. Both streams stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pscc_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam longint PiFix =
      longint'((PiQ30 + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
  localparam longint TwoPiFix =
      longint'((TwoPiQ30 + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
  localparam int WatchdogLimit = 5000;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 75;
  localparam int AngleMax      = 411774;
  localparam int PadW          = TdataW - 2 * AngleW - SpeedW;

  // Register indexes that the block does not decode.
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  typedef struct {
    logic signed [AngleW-1:0] pos_err;
    logic signed [SpeedW-1:0] spd_tgt;
    logic signed [IqW-1:0]    iq_ref;
  } loop_out_t;

  typedef struct {
    bit                       is_write;
    logic [CfgIdxW-1:0]       idx;
    logic [CfgDatW-1:0]       wdata;
    logic [AngleW-1:0]        tgt;
    logic [AngleW-1:0]        ang;
    logic signed [SpeedW-1:0] meas;
    bit                       typed;
    loop_out_t                want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  // Fields from bit 0: target_position, mech_angle, measured_speed, padding.
  logic [TdataW-1:0]  s_tdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // Fields from bit 0: position_error, speed_target, q_current_ref, padding.
  logic [TdataW-1:0]  m_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDatW-1:0] cfg_wdata = '0;

  // Controller model: settings and integrator as held by the block.
  longint pos_gain_r  = longint'(RstPositionGain);
  longint spd_gain_r  = longint'(RstSpeedGain);
  longint spd_igain_r = longint'(RstSpeedIGainDt);
  longint spd_floor_r = longint'(RstSpeedFloor);
  longint spd_ceil_r  = longint'(RstSpeedCeiling);
  longint cur_limit_r = longint'(RstCurrentLimit);
  longint integ_r     = 0;

  loop_out_t pending_outputs[$];
  bit        typed_now = 1'b0;
  loop_out_t typed_want;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  position_speed_cascade_controller_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One control tick: wrapped position error, clamped speed target and the
  // PI current reference. Products are floored by the arithmetic shift.
  function automatic loop_out_t cascade_step(logic [AngleW-1:0] tgt,
                                             logic [AngleW-1:0] ang,
                                             logic signed [SpeedW-1:0] meas);
    longint    err;
    longint    spd;
    longint    serr;
    longint    prop;
    loop_out_t o;
    err = longint'(tgt) - longint'(ang);
    if (err > PiFix) err -= TwoPiFix;
    else if (err < -PiFix) err += TwoPiFix;
    spd = clip((pos_gain_r * err) >>> FracBits, spd_floor_r, spd_ceil_r);
    serr = spd - longint'(meas);
    integ_r = clip(integ_r + ((spd_igain_r * serr) >>> FracBits),
                   -cur_limit_r, cur_limit_r);
    prop = (spd_gain_r * serr) >>> FracBits;
    o.pos_err = err[AngleW-1:0];
    o.spd_tgt = spd[SpeedW-1:0];
    o.iq_ref  = IqW'(clip(prop + integ_r, -cur_limit_r, cur_limit_r));
    return o;
  endfunction

  // Register write as the block decodes it; unknown indexes change nothing.
  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    case (idx)
      RegPositionGain: pos_gain_r = longint'(data[GainW-1:0]);
      RegSpeedGain:    spd_gain_r = longint'(data[GainW-1:0]);
      RegSpeedIGainDt: spd_igain_r = longint'(data[GainW-1:0]);
      RegSpeedFloor:   spd_floor_r = longint'(signed'(data));
      RegSpeedCeiling: spd_ceil_r = longint'(signed'(data));
      RegCurrentLimit: cur_limit_r = longint'(data[GainW-1:0]);
      default: ;
    endcase
  endtask

  task automatic flag_fault(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Check results, predict accepted requests and track register writes.
  always @(posedge clk_i) begin : monitor
    loop_out_t act;
    loop_out_t want;
    loop_out_t calc;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        act.pos_err = m_tdata[18:0];
        act.spd_tgt = m_tdata[45:19];
        act.iq_ref  = m_tdata[70:46];
        if (pending_outputs.size() == 0) begin
          flag_fault($sformatf("unrequested result err %0d spd %0d iq %0d",
                               act.pos_err, act.spd_tgt, act.iq_ref));
        end else begin
          want = pending_outputs.pop_front();
          if (act.pos_err !== want.pos_err || act.spd_tgt !== want.spd_tgt ||
              act.iq_ref !== want.iq_ref) begin
            flag_fault($sformatf(
                "mismatch: expected err %0d spd %0d iq %0d, got err %0d spd %0d iq %0d",
                want.pos_err, want.spd_tgt, want.iq_ref,
                act.pos_err, act.spd_tgt, act.iq_ref));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        calc = cascade_step(s_tdata[18:0], s_tdata[37:19], s_tdata[64:38]);
        pending_outputs.push_back(typed_now ? typed_want : calc);
      end
      if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Output back-pressure: calm stretches alternate with short and long stalls.
  initial begin : sink_pacing
    int hold;
    int calm_left;
    int r;
    bit calm;
    bit rdy;
    hold = 0;
    calm_left = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else if (calm) begin
        rdy = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        rdy = (r < 65);
        if (r >= 95) hold = $urandom_range(10, 60);
        else if (r >= 65) hold = $urandom_range(0, 3);
      end
      m_tready <= rdy;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  // Gains and limits: mostly moderate, now and then zero, full scale or wide.
  // The bits above the register width are random and must be ignored.
  function automatic logic [CfgDatW-1:0] pick_gain();
    logic [2:0]       top;
    logic [GainW-1:0] g;
    int               r;
    top = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    if (r == 0) g = '0;
    else if (r == 1) g = '1;
    else if (r < 4) g = GainW'($urandom);
    else g = GainW'($urandom_range(0, 1 << 18));
    return {top, g};
  endfunction

  function automatic stim_row_t wr_row(logic [CfgIdxW-1:0] idx,
                                       logic [CfgDatW-1:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.wdata = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(int tgt, int ang, int meas);
    stim_row_t row;
    row = '{default: '0};
    row.tgt = AngleW'(tgt);
    row.ang = AngleW'(ang);
    row.meas = SpeedW'(meas);
    return row;
  endfunction

  function automatic stim_row_t chk_row(int tgt, int ang, int meas,
                                        int e_err, int e_spd, int e_iq);
    stim_row_t row;
    row = item_row(tgt, ang, meas);
    row.typed = 1'b1;
    row.want.pos_err = AngleW'(e_err);
    row.want.spd_tgt = SpeedW'(e_spd);
    row.want.iq_ref  = IqW'(e_iq);
    return row;
  endfunction

  // Angles mostly in 0..2pi, sometimes anywhere in the field; speeds mostly
  // moderate, sometimes anywhere in the field.
  function automatic stim_row_t rand_item();
    stim_row_t row;
    row = '{default: '0};
    row.tgt = ($urandom_range(0, 9) == 0) ? AngleW'($urandom)
                                         : AngleW'($urandom_range(0, AngleMax));
    row.ang = ($urandom_range(0, 9) == 0) ? AngleW'($urandom)
                                         : AngleW'($urandom_range(0, AngleMax));
    if ($urandom_range(0, 9) < 6) row.meas = SpeedW'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    else row.meas = SpeedW'($urandom);
    return row;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_item(stim_row_t row, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tdata <= {{PadW{1'b0}}, row.meas, row.ang, row.tgt};
    s_tvalid <= 1'b1;
    typed_now = row.typed;
    typed_want = row.want;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Phase settings: defaults, full scale, zero current limit, then random.
  task automatic roll_settings(int ph);
    logic [CfgDatW-1:0] lo;
    logic [CfgDatW-1:0] hi;
    if (ph == 0) begin
      write_reg(RegPositionGain, CfgDatW'(RstPositionGain));
      write_reg(RegSpeedGain, CfgDatW'(RstSpeedGain));
      write_reg(RegSpeedIGainDt, CfgDatW'(RstSpeedIGainDt));
      write_reg(RegSpeedFloor, RstSpeedFloor);
      write_reg(RegSpeedCeiling, RstSpeedCeiling);
      write_reg(RegCurrentLimit, CfgDatW'(RstCurrentLimit));
    end else if (ph == 1) begin
      write_reg(RegPositionGain, '1);
      write_reg(RegSpeedGain, '1);
      write_reg(RegSpeedIGainDt, '1);
      write_reg(RegSpeedFloor, {1'b1, {(CfgDatW-1){1'b0}}});
      write_reg(RegSpeedCeiling, {1'b0, {(CfgDatW-1){1'b1}}});
      write_reg(RegCurrentLimit, '1);
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        lo = CfgDatW'(-int'($urandom_range(0, 1 << 25)));
        hi = CfgDatW'($urandom_range(0, 1 << 25));
      end else begin
        lo = CfgDatW'($urandom);
        hi = CfgDatW'($urandom);
      end
      write_reg(RegPositionGain, pick_gain());
      write_reg(RegSpeedGain, pick_gain());
      write_reg(RegSpeedIGainDt, pick_gain());
      write_reg(RegSpeedFloor, lo);
      write_reg(RegSpeedCeiling, hi);
      write_reg(RegCurrentLimit, (ph == 2) ? '0 : pick_gain());
    end
  endtask

  initial begin : stimulus
    stim_row_t dir_tab[$];
    int        ph;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: defaults, zero current limit, angle wrap edges, gain and
    // speed extremes, undecoded indexes, floor above ceiling.
    dir_tab = '{
      chk_row(0, 0, 0, 0, 0, 0),
      wr_row(RegCurrentLimit, '0),
      chk_row(65536, 0, 0, 65536, 65536, 0),
      chk_row(AngleMax, 0, 0, -1, -1, 0),
      chk_row(0, AngleMax, 0, 1, 1, 0),
      chk_row(0, 205888, 0, 205887, 205887, 0),
      chk_row(205887, 0, -67108864, 205887, 205887, 0),
      wr_row(RegPositionGain, 27'h0FFFFFF),
      chk_row(205887, 0, 67108863, 205887, 6553600, 0),
      chk_row(0, 205887, 0, -205887, -6553600, 0),
      wr_row(RegUnusedLo, '0),
      wr_row(RegUnusedHi, '1),
      item_row(524287, 0, 0),
      wr_row(RegCurrentLimit, '1),
      wr_row(RegSpeedGain, '1),
      wr_row(RegSpeedIGainDt, '1),
      item_row(524287, 524287, -67108864),
      item_row(0, 524287, 67108863),
      item_row(AngleMax, AngleMax, -1),
      wr_row(RegSpeedFloor, 27'h3FFFFFF),
      wr_row(RegSpeedCeiling, 27'h4000000),
      item_row(0, 0, 0),
      wr_row(RegSpeedFloor, '0),
      wr_row(RegSpeedCeiling, 27'h7FF0000),
      item_row(1, 0, 0),
      wr_row(RegSpeedFloor, 27'h4000000),
      wr_row(RegSpeedCeiling, 27'h3FFFFFF),
      wr_row(RegPositionGain, '0),
      item_row(AngleMax, 0, 67108863),
      item_row(0, 0, -67108864)
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_write) begin
        wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
      end else begin
        send_item(dir_tab[i], 1'b0);
      end
    end

    // Random phases, each under its own settings. Every phase opens with a
    // burst of back-to-back requests and drains fully half-way through.
    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      roll_settings(ph);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) wait_drained();
        send_item(rand_item(), n < 15);
      end
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
